// ===== sv/tor_pkg.sv =====
package tor_pkg;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
    localparam logic [ST_W-1:0] ST_SCAN  = 3'd1;
    localparam logic [ST_W-1:0] ST_FINAL = 3'd2;
    localparam logic [ST_W-1:0] ST_RDWT  = 3'd3;
    localparam logic [ST_W-1:0] ST_DONE  = 3'd4;

    typedef struct packed {
        logic is_newest;
        logic dropped;
        logic entry_valid;
    } res_flags_t;

endpackage

// ===== sv/time_ordered_ring_buffer.sv =====
// Keeps up to BUFFER_DEPTH records (time key and payload tag) in capture-time order in a
// single memory with a registered read. An insert (tuser 0) walks the stored records from
// the oldest, one memory read per cycle, and from the first record with a larger key on
// it shifts every record one slot forward by reading and writing back the same entry. An
// insert into a non-empty buffer lasts longer the more records are stored, as the single
// read port of the record memory reads them one by one. A read (tuser 1) of a position
// beyond the fill count skips the memory read. One transaction is worked on at a time, and
// the next is accepted while the previous result still waits in the output register.
module time_ordered_ring_buffer
    import tor_pkg::*;
#(
    parameter int BUFFER_DEPTH = 16,
    parameter int KEY_WIDTH    = 48,
    parameter int TAG_WIDTH    = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // time_key, payload_tag, read_position, zero fill to whole bytes
    input  logic [((KEY_WIDTH+TAG_WIDTH+$clog2(BUFFER_DEPTH)+7)/8)*8-1:0] s_axis_tdata,
    // opcode
    input  logic                s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // is_newest, dropped, fill_count, entry_valid, entry_key, entry_tag, zero fill
    output logic [((KEY_WIDTH+TAG_WIDTH+$clog2(BUFFER_DEPTH+1)+3+7)/8)*8-1:0] m_axis_tdata
);

    localparam int AW      = $clog2(BUFFER_DEPTH);
    localparam int CW      = $clog2(BUFFER_DEPTH + 1);
    localparam int DW      = KEY_WIDTH + TAG_WIDTH;
    localparam int OUT_RAW = KEY_WIDTH + TAG_WIDTH + CW + 3;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [DW-1:0] mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic [DW-1:0] mem_rd_data;

    logic                 res_valid;
    logic                 res_take;
    res_flags_t           res_flags;
    logic [CW-1:0]        res_fill;
    logic [KEY_WIDTH-1:0] res_key;
    logic [TAG_WIDTH-1:0] res_tag;

    logic                 m_valid_reg, m_valid_next;
    res_flags_t           m_flags_reg;
    logic [CW-1:0]        m_fill_reg;
    logic [KEY_WIDTH-1:0] m_key_reg;
    logic [TAG_WIDTH-1:0] m_tag_reg;

    tor_mem #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    tor_seq #(
        .DEPTH     (BUFFER_DEPTH),
        .KEY_WIDTH (KEY_WIDTH),
        .TAG_WIDTH (TAG_WIDTH),
        .AW        (AW),
        .CW        (CW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_opcode   (s_axis_tuser),
        .in_key      (s_axis_tdata[KEY_WIDTH-1:0]),
        .in_tag      (s_axis_tdata[KEY_WIDTH+TAG_WIDTH-1:KEY_WIDTH]),
        .in_pos      (s_axis_tdata[KEY_WIDTH+TAG_WIDTH+AW-1:KEY_WIDTH+TAG_WIDTH]),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res_flags   (res_flags),
        .res_fill    (res_fill),
        .res_key     (res_key),
        .res_tag     (res_tag)
    );

    assign res_take = res_valid && (!m_valid_reg || m_axis_tready);

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (res_take)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            m_flags_reg <= res_flags;
            m_fill_reg  <= res_fill;
            m_key_reg   <= res_key;
            m_tag_reg   <= res_tag;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_W'({m_tag_reg, m_key_reg, m_flags_reg.entry_valid, m_fill_reg,
                                   m_flags_reg.dropped, m_flags_reg.is_newest});

endmodule

// ===== sv/tor_mem.sv =====
module tor_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 64
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] store_reg [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/tor_seq.sv =====
module tor_seq
    import tor_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 48,
    parameter int TAG_WIDTH = 16,
    parameter int AW        = 4,
    parameter int CW        = 5
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     in_opcode,
    input  logic [KEY_WIDTH-1:0]     in_key,
    input  logic [TAG_WIDTH-1:0]     in_tag,
    input  logic [AW-1:0]            in_pos,
    output logic                     mem_wr_en,
    output logic [AW-1:0]            mem_wr_addr,
    output logic [KEY_WIDTH+TAG_WIDTH-1:0] mem_wr_data,
    output logic                     mem_rd_en,
    output logic [AW-1:0]            mem_rd_addr,
    input  logic [KEY_WIDTH+TAG_WIDTH-1:0] mem_rd_data,
    output logic                     res_valid,
    input  logic                     res_take,
    output res_flags_t               res_flags,
    output logic [CW-1:0]            res_fill,
    output logic [KEY_WIDTH-1:0]     res_key,
    output logic [TAG_WIDTH-1:0]     res_tag
);

    localparam int SW = AW + 1;

    logic [ST_W-1:0]      state_reg, state_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        fill_reg, fill_next;
    logic [CW-1:0]        issue_reg, issue_next;
    logic [AW-1:0]        rd_slot_reg, rd_slot_next;
    logic                 pend_reg, pend_next;
    logic [AW-1:0]        pend_slot_reg, pend_slot_next;
    logic                 pend_first_reg, pend_first_next;
    logic                 found_reg, found_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [KEY_WIDTH-1:0] carry_key_reg, carry_key_next;
    logic [TAG_WIDTH-1:0] carry_tag_reg, carry_tag_next;
    res_flags_t           flags_reg, flags_next;
    logic [CW-1:0]        out_fill_reg, out_fill_next;
    logic [KEY_WIDTH-1:0] out_key_reg, out_key_next;
    logic [TAG_WIDTH-1:0] out_tag_reg, out_tag_next;

    logic [SW-1:0]        head_w;
    logic [SW-1:0]        count_w;
    logic [SW-1:0]        oldest_w;
    logic [SW-1:0]        rsum_w;
    logic [AW-1:0]        read_slot;
    logic [KEY_WIDTH-1:0] rd_key;
    logic [TAG_WIDTH-1:0] rd_tag;
    logic                 hit;

    assign rd_key = mem_rd_data[KEY_WIDTH+TAG_WIDTH-1:TAG_WIDTH];
    assign rd_tag = mem_rd_data[TAG_WIDTH-1:0];

    // The oldest record sits count slots behind the write head.
    assign head_w   = SW'(head_reg);
    assign count_w  = SW'(count_reg);
    assign oldest_w = (head_w >= count_w) ? (head_w - count_w)
                                          : (head_w + SW'(DEPTH) - count_w);
    assign rsum_w    = oldest_w + SW'(in_pos);
    assign read_slot = (rsum_w >= SW'(DEPTH)) ? AW'(rsum_w - SW'(DEPTH)) : AW'(rsum_w);

    assign hit = found_reg || (rd_key > key_reg);

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res_flags = flags_reg;
    assign res_fill  = out_fill_reg;
    assign res_key   = out_key_reg;
    assign res_tag   = out_tag_reg;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        fill_next       = fill_reg;
        issue_next      = issue_reg;
        rd_slot_next    = rd_slot_reg;
        pend_next       = 1'b0;
        pend_slot_next  = pend_slot_reg;
        pend_first_next = 1'b0;
        found_next      = found_reg;
        key_next        = key_reg;
        carry_key_next  = carry_key_reg;
        carry_tag_next  = carry_tag_reg;
        flags_next      = flags_reg;
        out_fill_next   = out_fill_reg;
        out_key_next    = out_key_reg;
        out_tag_next    = out_tag_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = pend_slot_reg;
        mem_wr_data     = {carry_key_reg, carry_tag_reg};
        mem_rd_en       = 1'b0;
        mem_rd_addr     = rd_slot_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    flags_next    = '0;
                    out_fill_next = count_reg;
                    out_key_next  = '0;
                    out_tag_next  = '0;
                    if (in_opcode == OP_INSERT)
                    begin
                        key_next       = in_key;
                        carry_key_next = in_key;
                        carry_tag_next = in_tag;
                        fill_next      = count_reg;
                        issue_next     = '0;
                        rd_slot_next   = AW'(oldest_w);
                        found_next     = 1'b0;
                        state_next     = ST_SCAN;
                    end
                    else if (CW'(in_pos) < count_reg)
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = read_slot;
                        state_next  = ST_RDWT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue_reg < fill_reg)
                begin
                    mem_rd_en       = 1'b1;
                    mem_rd_addr     = rd_slot_reg;
                    rd_slot_next    = (rd_slot_reg == AW'(DEPTH - 1)) ? '0
                                                                      : rd_slot_reg + 1'b1;
                    issue_next      = issue_reg + 1'b1;
                    pend_next       = 1'b1;
                    pend_slot_next  = rd_slot_reg;
                    pend_first_next = (issue_reg == '0);
                end
                if (pend_reg && hit)
                begin
                    if (!found_reg && pend_first_reg && (fill_reg == CW'(DEPTH)))
                    begin
                        // Full and older than every stored record: nothing is written.
                        flags_next.dropped = 1'b1;
                        pend_next          = 1'b0;
                        state_next         = ST_DONE;
                    end
                    else
                    begin
                        mem_wr_en      = 1'b1;
                        found_next     = 1'b1;
                        carry_key_next = rd_key;
                        carry_tag_next = rd_tag;
                    end
                end
                if (!pend_reg && (issue_reg == fill_reg))
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                // The last carried record lands at the head, over the oldest one when full.
                mem_wr_en            = 1'b1;
                mem_wr_addr          = head_reg;
                head_next            = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
                count_next           = (fill_reg == CW'(DEPTH)) ? fill_reg : fill_reg + 1'b1;
                out_fill_next        = count_next;
                flags_next.is_newest = !found_reg;
                state_next           = ST_DONE;
            end
            ST_RDWT:
            begin
                flags_next.entry_valid = 1'b1;
                out_key_next           = rd_key;
                out_tag_next           = rd_tag;
                state_next             = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_reg       <= fill_next;
        issue_reg      <= issue_next;
        rd_slot_reg    <= rd_slot_next;
        pend_slot_reg  <= pend_slot_next;
        pend_first_reg <= pend_first_next;
        found_reg      <= found_next;
        key_reg        <= key_next;
        carry_key_reg  <= carry_key_next;
        carry_tag_reg  <= carry_tag_next;
        flags_reg      <= flags_next;
        out_fill_reg   <= out_fill_next;
        out_key_reg    <= out_key_next;
        out_tag_reg    <= out_tag_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("Record count exceeds the buffer depth.");

    a_no_same_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
        else $error("Read and write hit the same slot in one cycle.");

    a_wr_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> (SW'(mem_wr_addr) < SW'(DEPTH)))
        else $error("Write address beyond the buffer depth.");

    a_drop_result: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_flags.dropped) |->
            (!res_flags.is_newest && (res_fill == CW'(DEPTH))))
        else $error("Dropped record reported with a wrong fill or newest flag.");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_reg)
        else $error("Pending memory read left over in idle.");

endmodule

// ===== tb/testbench.sv =====
module testbench
    import tor_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH     = 16;
    localparam int KEY_W     = 48;
    localparam int TAG_W     = 16;
    localparam int POS_W     = $clog2(DEPTH);
    localparam int FILL_W    = $clog2(DEPTH + 1);
    localparam int IN_W      = ((KEY_W + TAG_W + POS_W + 7) / 8) * 8;
    localparam int OUT_W     = ((KEY_W + TAG_W + FILL_W + 3 + 7) / 8) * 8;
    localparam int IDLE_LIMIT = 4000;
    localparam int RANDOM_PER_PHASE = 150;

    typedef struct {
        logic             op;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic [POS_W-1:0] pos;
    } buf_op_t;

    typedef struct {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } record_t;

    typedef struct {
        logic              is_newest;
        logic              dropped;
        logic [FILL_W-1:0] fill_count;
        logic              entry_valid;
        logic [KEY_W-1:0]  entry_key;
        logic [TAG_W-1:0]  entry_tag;
    } outcome_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic             s_axis_tuser = OP_INSERT;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    buf_op_t  queued_ops[$];
    outcome_t pending_outcomes[$];
    record_t  ordered_records[$];
    buf_op_t  driven_op;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fail_count = 0;
    int idle_cycles = 0;
    int accepted_ops = 0;
    int drop_count = 0;
    int newest_count = 0;
    int valid_reads = 0;
    int phase_idx;
    int n;
    logic [KEY_W-1:0] key_cursor = '0;

    time_ordered_ring_buffer #(
        .BUFFER_DEPTH(DEPTH),
        .KEY_WIDTH   (KEY_W),
        .TAG_WIDTH   (TAG_W)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic outcome_t apply_sorted_op(input buf_op_t op);
        outcome_t res;
        record_t  rec;
        int       fill;
        int       slot;
        res  = '{default: '0};
        fill = ordered_records.size();
        if (op.op == OP_INSERT)
        begin
            rec.key = op.key;
            rec.tag = op.tag;
            slot = 0;
            while (slot < fill && ordered_records[slot].key <= op.key)
                slot++;
            res.is_newest = (slot == fill);
            if (fill >= DEPTH && slot == 0)
            begin
                res.dropped   = 1'b1;
                res.is_newest = 1'b0;
            end
            else
            begin
                if (fill >= DEPTH)
                begin
                    void'(ordered_records.pop_front());
                    slot--;
                end
                ordered_records.insert(slot, rec);
            end
        end
        else if (op.pos < ordered_records.size())
        begin
            res.entry_valid = 1'b1;
            res.entry_key   = ordered_records[op.pos].key;
            res.entry_tag   = ordered_records[op.pos].tag;
        end
        res.fill_count = FILL_W'(ordered_records.size());
        return res;
    endfunction

    task automatic check_outcome(input logic [OUT_W-1:0] data);
        outcome_t exp;
        outcome_t act;
        act.is_newest   = data[0];
        act.dropped     = data[1];
        act.fill_count  = data[2 +: FILL_W];
        act.entry_valid = data[2 + FILL_W];
        act.entry_key   = data[3 + FILL_W +: KEY_W];
        act.entry_tag   = data[3 + FILL_W + KEY_W +: TAG_W];
        if (pending_outcomes.size() == 0)
        begin
            $error("Result transaction arrived with no outstanding request: %h", data);
            fail_count++;
        end
        else
        begin
            exp = pending_outcomes.pop_front();
            if (act.is_newest !== exp.is_newest)
            begin
                $error("is_newest: expected %0h, got %0h", exp.is_newest, act.is_newest);
                fail_count++;
            end
            if (act.dropped !== exp.dropped)
            begin
                $error("dropped: expected %0h, got %0h", exp.dropped, act.dropped);
                fail_count++;
            end
            if (act.fill_count !== exp.fill_count)
            begin
                $error("fill_count: expected %0d, got %0d", exp.fill_count, act.fill_count);
                fail_count++;
            end
            if (act.entry_valid !== exp.entry_valid)
            begin
                $error("entry_valid: expected %0h, got %0h", exp.entry_valid, act.entry_valid);
                fail_count++;
            end
            if (act.entry_key !== exp.entry_key)
            begin
                $error("entry_key: expected %h, got %h", exp.entry_key, act.entry_key);
                fail_count++;
            end
            if (act.entry_tag !== exp.entry_tag)
            begin
                $error("entry_tag: expected %h, got %h", exp.entry_tag, act.entry_tag);
                fail_count++;
            end
        end
    endtask

    task automatic push_op(input logic op, input logic [KEY_W-1:0] key,
                           input logic [TAG_W-1:0] tag, input logic [POS_W-1:0] pos);
        buf_op_t item;
        item.op  = op;
        item.key = key;
        item.tag = tag;
        item.pos = pos;
        queued_ops.push_back(item);
    endtask

    task automatic push_random_op();
        logic [KEY_W-1:0] key;
        int               mode;
        mode = $urandom_range(0, 9);
        if (mode < 2)
            key = KEY_W'($urandom_range(0, 15));
        else if (mode < 6)
            key = key_cursor + KEY_W'($urandom_range(0, 1000));
        else
            key = KEY_W'({$urandom, $urandom});
        if (mode >= 2 && key > key_cursor)
            key_cursor = key;
        push_op(($urandom_range(0, 99) < 60) ? OP_INSERT : OP_READ, key,
                TAG_W'($urandom), POS_W'($urandom));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= OP_INSERT;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                outcome_t res;
                res = apply_sorted_op(driven_op);
                pending_outcomes.push_back(res);
                accepted_ops++;
                drop_count   += res.dropped;
                newest_count += res.is_newest;
                valid_reads  += res.entry_valid;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (queued_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    driven_op = queued_ops.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_W'({driven_op.pos, driven_op.tag, driven_op.key});
                    s_axis_tuser  <= driven_op.op;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_outcome(m_axis_tdata);
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Stopped after %0d accepted transactions with no progress.",
                         accepted_ops);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        push_op(OP_READ, '0, '0, POS_W'(0));
        push_op(OP_READ, '1, '1, '1);
        push_op(OP_INSERT, '1, '1, '1);
        push_op(OP_INSERT, '0, '0, '0);
        push_op(OP_INSERT, '0, TAG_W'(1), '0);
        push_op(OP_INSERT, {1'b1, {(KEY_W-1){1'b0}}}, {TAG_W/2{2'b10}}, '0);
        push_op(OP_READ, '0, '0, POS_W'(0));
        push_op(OP_READ, '0, '0, POS_W'(3));
        push_op(OP_READ, '0, '0, POS_W'(4));
        for (n = 0; n < DEPTH - 4; n++)
            push_op(OP_INSERT, KEY_W'(256 + 16 * n), TAG_W'(16'h5a00 + n), POS_W'(n));
        push_op(OP_INSERT, '1, TAG_W'(16'h0f0f), '0);
        push_op(OP_INSERT, '1, TAG_W'(16'hf0f0), '0);
        push_op(OP_INSERT, '0, TAG_W'(16'hdead), '0);
        push_op(OP_READ, '0, '0, '1);

        for (phase_idx = 0; phase_idx < 4; phase_idx++)
        begin
            case (phase_idx)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 78;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 78;
                end
                default:
                begin
                    send_idle_pct = 13;
                    recv_stall_pct = 13;
                end
            endcase
            for (n = 0; n < RANDOM_PER_PHASE; n++)
                push_random_op();
            wait (queued_ops.size() == 0);
        end

        @(posedge clk);
        wait (!s_axis_tvalid && pending_outcomes.size() == 0);
        repeat (4 * DEPTH) @(posedge clk);

        if (pending_outcomes.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_outcomes.size());
            fail_count++;
        end
        $display("Accepted %0d insert/read transactions over four handshake pressure phases.",
                 accepted_ops);
        $display("Saw %0d newest inserts, %0d full-buffer drops and %0d valid reads.",
                 newest_count, drop_count, valid_reads);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== time_ordered_ring_buffer.f =====
sv/tor_pkg.sv
sv/tor_mem.sv
sv/tor_seq.sv
sv/time_ordered_ring_buffer.sv
tb/testbench.sv
